// ===== rtl/pgv_pkg.sv =====
package pgv_pkg;

  localparam int CoordW  = 20;
  localparam int VelW    = 32;
  localparam int GainW   = 32;
  localparam int TagW    = 8;
  localparam int CfgDataW = 32;
  localparam int CfgIdxW  = 2;

  // signed difference, squares, root and cube
  localparam int DiffW  = CoordW + 1;
  localparam int SqW    = 2 * DiffW;
  localparam int RootW  = DiffW;
  localparam int CubeW  = 3 * RootW;
  localparam int ProdW  = CoordW + GainW;
  localparam int QuotW  = 34;
  localparam int FracSh = 24;
  localparam int SumW   = QuotW + 2;

  localparam int SqSteps  = RootW;
  localparam int DivSteps = QuotW;

  // stage map: 0 diff, 1 squares, 2 sum/capture, sqrt, 2 multiply, divide setup, divide
  localparam int SqBase  = 2;
  localparam int MulA    = SqBase + SqSteps + 1;
  localparam int MulB    = MulA + 1;
  localparam int DivBase = MulB + 1;
  localparam int NumStg  = DivBase + DivSteps + 1;

  localparam logic [CoordW-1:0] CentreRst = 20'd102400;
  localparam logic [CoordW-1:0] RadiusRst = 20'd6656;
  localparam logic [GainW-1:0]  GainRst   = 32'd0;
  localparam logic [DiffW-1:0]  ShipMargin = 21'd2560;
  localparam logic [QuotW-1:0]  DeltaClamp = 34'h2_0000_0000;

  localparam logic KindShip = 1'b0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTRE_X = 2'd0,
    REG_CENTRE_Y = 2'd1,
    REG_RADIUS   = 2'd2,
    REG_GAIN     = 2'd3
  } pgv_reg_t;

  typedef struct packed {
    logic [TagW-1:0]         tag;
    logic signed [VelW-1:0]  vel_x;
    logic signed [VelW-1:0]  vel_y;
    logic signed [DiffW-1:0] ex;
    logic signed [DiffW-1:0] ey;
    logic                    cap;
  } pgv_carry_t;

  // add or subtract the increment, saturate to the velocity range
  function automatic logic [VelW-1:0] sat_add(input logic signed [VelW-1:0] v,
                                              input logic neg,
                                              input logic [QuotW-1:0] delta);
    logic signed [SumW-1:0] vx;
    logic signed [SumW-1:0] dx;
    logic signed [SumW-1:0] sum;
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    vx  = SumW'(v);
    dx  = $signed({2'b00, delta});
    sum = neg ? (vx - dx) : (vx + dx);
    hi  = $signed({{(SumW-VelW+1){1'b0}}, {(VelW-1){1'b1}}});
    lo  = -hi - SumW'(1);
    if (sum > hi) begin
      sat_add = hi[VelW-1:0];
    end else if (sum < lo) begin
      sat_add = lo[VelW-1:0];
    end else begin
      sat_add = sum[VelW-1:0];
    end
  endfunction

endpackage

// ===== rtl/pgv_if.sv =====
interface pgv_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  kind;
  logic [pgv_pkg::TagW-1:0]              body_tag;
  logic [pgv_pkg::CoordW-1:0]            pos_x;
  logic [pgv_pkg::CoordW-1:0]            pos_y;
  logic signed [pgv_pkg::VelW-1:0]       vel_x;
  logic signed [pgv_pkg::VelW-1:0]       vel_y;

  modport source (output valid, kind, body_tag, pos_x, pos_y, vel_x, vel_y, input ready);
  modport sink   (input valid, kind, body_tag, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

interface pgv_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [pgv_pkg::TagW-1:0]              tag_out;
  logic signed [pgv_pkg::VelW-1:0]       new_vel_x;
  logic signed [pgv_pkg::VelW-1:0]       new_vel_y;
  logic                                  captured;

  modport source (output valid, tag_out, new_vel_x, new_vel_y, captured, input ready);
  modport sink   (input valid, tag_out, new_vel_x, new_vel_y, captured, output ready);
endinterface

// ===== rtl/point_gravity_velocity_update_top.sv =====
// Throughput: one transaction per cycle unless the output stalls; the 34-step divider
// and the 21-step root extraction are fully pipelined, one stage per result bit.
// A stalled output holds the pipe only when its last stage is occupied.
// Reset (rst_n low, synchronous) empties the pipe and output and loads the
// register defaults: centre 400 px, capture radius 26 px, gain zero.
module point_gravity_velocity_update_top (
  input  logic                             clk,
  input  logic                             rst_n,
  pgv_in_if.sink                           in_bus,
  pgv_out_if.source                        out_bus,
  input  logic                             cfg_we,
  input  logic [pgv_pkg::CfgIdxW-1:0]      cfg_idx,
  input  logic [pgv_pkg::CfgDataW-1:0]     cfg_data
);

  localparam int NumStg   = pgv_pkg::NumStg;
  localparam int SqSteps  = pgv_pkg::SqSteps;
  localparam int DivSteps = pgv_pkg::DivSteps;
  localparam int MulA     = pgv_pkg::MulA;
  localparam int Last     = NumStg - 1;

  // ---------------------------------------------------------------- registers
  logic [pgv_pkg::CoordW-1:0] centre_x_r, centre_y_r, radius_r;
  logic [pgv_pkg::GainW-1:0]  gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_x_r <= pgv_pkg::CentreRst;
      centre_y_r <= pgv_pkg::CentreRst;
      radius_r   <= pgv_pkg::RadiusRst;
      gain_r     <= pgv_pkg::GainRst;
    end else if (cfg_we) begin
      unique case (pgv_pkg::pgv_reg_t'(cfg_idx))
        pgv_pkg::REG_CENTRE_X: centre_x_r <= cfg_data[pgv_pkg::CoordW-1:0];
        pgv_pkg::REG_CENTRE_Y: centre_y_r <= cfg_data[pgv_pkg::CoordW-1:0];
        pgv_pkg::REG_RADIUS:   radius_r   <= cfg_data[pgv_pkg::CoordW-1:0];
        pgv_pkg::REG_GAIN:     gain_r     <= cfg_data[pgv_pkg::GainW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  // The whole pipe advances together. It freezes only when the last stage holds a
  // transaction and the output register cannot take it; bubbles keep flowing.
  logic                    en;
  logic [NumStg-1:0]       vld_r;
  pgv_pkg::pgv_carry_t     car_r [NumStg];
  logic                    out_valid_r;
  logic                    out_load;

  assign out_load     = out_bus.ready || !out_valid_r;
  assign en           = out_load || !vld_r[Last];
  assign in_bus.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NumStg-2:0], in_bus.valid};
    end
  end

  // ---------------------------------------------------------------- stage 0
  // Offsets from the centre and the effective capture radius.
  pgv_pkg::pgv_carry_t           car0_nxt;
  logic [pgv_pkg::DiffW-1:0]     rad_nxt;
  logic [pgv_pkg::DiffW-1:0]     rad_r;

  always_comb begin
    car0_nxt.tag   = in_bus.body_tag;
    car0_nxt.vel_x = in_bus.vel_x;
    car0_nxt.vel_y = in_bus.vel_y;
    car0_nxt.ex    = $signed({1'b0, centre_x_r}) - $signed({1'b0, in_bus.pos_x});
    car0_nxt.ey    = $signed({1'b0, centre_y_r}) - $signed({1'b0, in_bus.pos_y});
    car0_nxt.cap   = 1'b0;
    rad_nxt        = {1'b0, radius_r} +
                     ((in_bus.kind == pgv_pkg::KindShip) ? pgv_pkg::ShipMargin : '0);
  end

  // ---------------------------------------------------------------- stage 1
  // Squares of both offsets and of the radius.
  logic signed [pgv_pkg::SqW-1:0] sqx_nxt, sqy_nxt;
  logic [pgv_pkg::SqW-1:0]        sqx_r, sqy_r, rr_r;

  assign sqx_nxt = car_r[0].ex * car_r[0].ex;
  assign sqy_nxt = car_r[0].ey * car_r[0].ey;

  // ---------------------------------------------------------------- stage 2
  // Distance squared and the exact capture test; zero distance always captures.
  logic [pgv_pkg::SqW-1:0]   dist_sq;
  pgv_pkg::pgv_carry_t       car2_nxt;

  always_comb begin
    dist_sq      = sqx_r + sqy_r;
    car2_nxt     = car_r[1];
    car2_nxt.cap = (dist_sq == '0) || (dist_sq < rr_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      car_r[0] <= car0_nxt;
      rad_r    <= rad_nxt;
      car_r[1] <= car_r[0];
      sqx_r    <= sqx_nxt[pgv_pkg::SqW-1:0];
      sqy_r    <= sqy_nxt[pgv_pkg::SqW-1:0];
      rr_r     <= rad_r * rad_r;
      car_r[2] <= car2_nxt;
      for (int i = 3; i < NumStg; i++) begin
        car_r[i] <= car_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- square root
  // Digit-by-digit root, one bit a stage, MSB first. The remainder tracks
  // dist_sq - root^2, so each step is a shifted add and one compare.
  logic [pgv_pkg::SqW-1:0]   sq_rem_r  [SqSteps+1];
  logic [pgv_pkg::RootW-1:0] sq_root_r [SqSteps+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem_r[0]  <= dist_sq;
      sq_root_r[0] <= '0;
    end
  end

  for (genvar i = 1; i <= SqSteps; i++) begin : g_sqrt
    localparam int K = SqSteps - i;
    logic [pgv_pkg::SqW+1:0]   trial;
    logic                      take;
    logic [pgv_pkg::SqW-1:0]   rem_nxt;
    logic [pgv_pkg::RootW-1:0] root_nxt;

    always_comb begin
      trial    = ({{(pgv_pkg::SqW+2-pgv_pkg::RootW){1'b0}}, sq_root_r[i-1]} << (K + 1))
               + ((pgv_pkg::SqW+2)'(1) << (2 * K));
      take     = {2'b00, sq_rem_r[i-1]} >= trial;
      rem_nxt  = take ? (sq_rem_r[i-1] - trial[pgv_pkg::SqW-1:0]) : sq_rem_r[i-1];
      root_nxt = take ? (sq_root_r[i-1] | (pgv_pkg::RootW'(1) << K)) : sq_root_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[i]  <= rem_nxt;
        sq_root_r[i] <= root_nxt;
      end
    end
  end

  // ---------------------------------------------------------------- cube, products
  logic [pgv_pkg::DiffW-1:0]  magx, magy;
  logic [pgv_pkg::SqW-1:0]    d2_r;
  logic [pgv_pkg::RootW-1:0]  d1_r;
  logic [pgv_pkg::ProdW-1:0]  pxa_r, pya_r, pxb_r, pyb_r;
  logic [pgv_pkg::CubeW-1:0]  cube_r;

  assign magx = car_r[MulA-1].ex[pgv_pkg::DiffW-1] ? (-car_r[MulA-1].ex) : car_r[MulA-1].ex;
  assign magy = car_r[MulA-1].ey[pgv_pkg::DiffW-1] ? (-car_r[MulA-1].ey) : car_r[MulA-1].ey;

  always_ff @(posedge clk) begin
    if (en) begin
      d2_r   <= sq_root_r[SqSteps] * sq_root_r[SqSteps];
      d1_r   <= sq_root_r[SqSteps];
      pxa_r  <= magx[pgv_pkg::CoordW-1:0] * gain_r;
      pya_r  <= magy[pgv_pkg::CoordW-1:0] * gain_r;
      cube_r <= d2_r * d1_r;
      pxb_r  <= pxa_r;
      pyb_r  <= pya_r;
    end
  end

  // ---------------------------------------------------------------- divider
  // Quotient floor(p * 2^24 / cube); from 2^34 up it is replaced by 2^33. The clamp
  // is decided up front; below it the quotient fits 34 bits, one bit a stage.
  localparam int NLoW = pgv_pkg::QuotW;
  localparam int RemW = pgv_pkg::CubeW;
  localparam int LowP = NLoW - pgv_pkg::FracSh;

  logic [pgv_pkg::CubeW-1:0] dv_c_r     [DivSteps+1];
  logic [RemW-1:0]           dv_rem_r   [2][DivSteps+1];
  logic [NLoW-1:0]           dv_nlo_r   [2][DivSteps+1];
  logic [pgv_pkg::QuotW-1:0] dv_q_r     [2][DivSteps+1];
  logic                      dv_clamp_r [2][DivSteps+1];

  logic [pgv_pkg::ProdW-1:0] prod_lane [2];
  assign prod_lane[0] = pxb_r;
  assign prod_lane[1] = pyb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dv_c_r[0] <= cube_r;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    always_ff @(posedge clk) begin
      if (en) begin
        dv_clamp_r[l][0] <= {{(pgv_pkg::CubeW+LowP-pgv_pkg::ProdW){1'b0}}, prod_lane[l]}
                            >= {cube_r, {LowP{1'b0}}};
        dv_rem_r[l][0]   <= RemW'(prod_lane[l][pgv_pkg::ProdW-1:LowP]);
        dv_nlo_r[l][0]   <= {prod_lane[l][LowP-1:0], {pgv_pkg::FracSh{1'b0}}};
        dv_q_r[l][0]     <= '0;
      end
    end

    for (genvar j = 1; j <= DivSteps; j++) begin : g_div
      logic [RemW:0]             rem_sh;
      logic                      ge;
      logic [RemW-1:0]           rem_nxt;

      always_comb begin
        rem_sh  = {dv_rem_r[l][j-1], dv_nlo_r[l][j-1][NLoW-1]};
        ge      = rem_sh >= {1'b0, dv_c_r[j-1]};
        rem_nxt = ge ? RemW'(rem_sh - {1'b0, dv_c_r[j-1]}) : rem_sh[RemW-1:0];
      end

      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem_r[l][j]   <= rem_nxt;
          dv_nlo_r[l][j]   <= {dv_nlo_r[l][j-1][NLoW-2:0], 1'b0};
          dv_q_r[l][j]     <= {dv_q_r[l][j-1][pgv_pkg::QuotW-2:0], ge};
          dv_clamp_r[l][j] <= dv_clamp_r[l][j-1];
        end
      end
    end
  end

  for (genvar j = 1; j <= DivSteps; j++) begin : g_cdiv
    always_ff @(posedge clk) begin
      if (en) begin
        dv_c_r[j] <= dv_c_r[j-1];
      end
    end
  end

  // ---------------------------------------------------------------- output
  // Apply the increment with saturation; a captured body passes through as is.
  logic [pgv_pkg::QuotW-1:0] delta_x, delta_y;
  logic [pgv_pkg::VelW-1:0]  nvx_nxt, nvy_nxt;
  logic [pgv_pkg::TagW-1:0]  tag_r;
  logic [pgv_pkg::VelW-1:0]  nvx_r, nvy_r;
  logic                      cap_r;

  always_comb begin
    delta_x = dv_clamp_r[0][DivSteps] ? pgv_pkg::DeltaClamp : dv_q_r[0][DivSteps];
    delta_y = dv_clamp_r[1][DivSteps] ? pgv_pkg::DeltaClamp : dv_q_r[1][DivSteps];
    if (car_r[Last].cap) begin
      nvx_nxt = car_r[Last].vel_x;
      nvy_nxt = car_r[Last].vel_y;
    end else begin
      nvx_nxt = pgv_pkg::sat_add(car_r[Last].vel_x, car_r[Last].ex[pgv_pkg::DiffW-1], delta_x);
      nvy_nxt = pgv_pkg::sat_add(car_r[Last].vel_y, car_r[Last].ey[pgv_pkg::DiffW-1], delta_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= vld_r[Last];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && vld_r[Last]) begin
      tag_r <= car_r[Last].tag;
      nvx_r <= nvx_nxt;
      nvy_r <= nvy_nxt;
      cap_r <= car_r[Last].cap;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.tag_out   = tag_r;
  assign out_bus.new_vel_x = nvx_r;
  assign out_bus.new_vel_y = nvy_r;
  assign out_bus.captured  = cap_r;

  // ---------------------------------------------------------------- checks
  // Root remainder never exceeds twice the root: floor sqrt is exact.
  a_sqrt_floor: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[MulA-1] |->
      ({1'b0, sq_rem_r[SqSteps]} <= {{(pgv_pkg::SqW-pgv_pkg::RootW){1'b0}},
                                     sq_root_r[SqSteps], 1'b0}))
    else $error("root remainder out of range");

  // Unclamped, uncaptured x-lane division leaves a remainder below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[Last] && !car_r[Last].cap && !dv_clamp_r[0][DivSteps]) |->
      (dv_rem_r[0][DivSteps] < dv_c_r[DivSteps]))
    else $error("divider remainder not below divisor");

  // A transaction waiting in the last stage is held while the output stalls.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[Last] && !en) |=> (vld_r[Last] && $stable(car_r[Last].tag)))
    else $error("stalled transaction lost");

endmodule
